FILE: hw/rtl/sha1_message_hasher_assert.svh
// Assertion macros shared by the SHA-1 message hasher RTL.
`ifndef SHA1_MESSAGE_HASHER_ASSERT_SVH
`define SHA1_MESSAGE_HASHER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SHA1MH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SHA1MH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sha1mh_pkg.sv
// Types, constants and round functions of the SHA-1 message hasher.
package sha1mh_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_ZERO,
        ST_LEN,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_work;

    typedef logic [511:0] t_blk;

    localparam t_work H_INIT = '{
        a: 32'h67452301,
        b: 32'hEFCDAB89,
        c: 32'h98BADCFE,
        d: 32'h10325476,
        e: 32'hC3D2E1F0
    };

    localparam logic [31:0] K_0  = 32'h5A827999;
    localparam logic [31:0] K_20 = 32'h6ED9EBA1;
    localparam logic [31:0] K_40 = 32'h8F1BBCDC;
    localparam logic [31:0] K_60 = 32'hCA62C1D6;

    localparam logic [6:0] ROUND_LAST   = 7'd79;
    localparam logic [6:0] ROUND_SCHED  = 7'd16;
    localparam logic [6:0] ROUND_PAR1   = 7'd20;
    localparam logic [6:0] ROUND_MAJ    = 7'd40;
    localparam logic [6:0] ROUND_PAR2   = 7'd60;
    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam logic [5:0] FILL_LEN     = 6'd56;
    localparam logic [5:0] FILL_LAST    = 6'd63;
    localparam logic [2:0] WORD_LAST    = 3'd4;

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] r;
        if (t < ROUND_PAR1) begin
            r = (b & c) | (~b & d);
        end else if (t < ROUND_MAJ) begin
            r = b ^ c ^ d;
        end else if (t < ROUND_PAR2) begin
            r = (b & c) | (b & d) | (c & d);
        end else begin
            r = b ^ c ^ d;
        end
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] r;
        if (t < ROUND_PAR1) begin
            r = K_0;
        end else if (t < ROUND_MAJ) begin
            r = K_20;
        end else if (t < ROUND_PAR2) begin
            r = K_40;
        end else begin
            r = K_60;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/sha1mh_round.sv
// One SHA-1 round with its message schedule step, shared by all 80 rounds.
module sha1mh_round (
    input  logic [6:0]         i_round,
    input  sha1mh_pkg::t_work  i_work,
    input  sha1mh_pkg::t_blk   i_blk,
    output sha1mh_pkg::t_work  o_work,
    output logic [31:0]        o_wt
);

    logic [31:0] sched_x;
    logic [31:0] f_val;
    logic [31:0] k_val;

    // Oldest word sits at the top of the window and the newest at the bottom.
    assign sched_x = i_blk[511:480] ^ i_blk[447:416] ^ i_blk[255:224] ^ i_blk[95:64];
    assign o_wt    = (i_round < sha1mh_pkg::ROUND_SCHED) ? i_blk[511:480]
                                                         : {sched_x[30:0], sched_x[31]};

    assign f_val = sha1mh_pkg::round_f(i_round, i_work.b, i_work.c, i_work.d);
    assign k_val = sha1mh_pkg::round_k(i_round);

    always_comb begin
        o_work.a = {i_work.a[26:0], i_work.a[31:27]} + f_val + i_work.e + o_wt + k_val;
        o_work.b = i_work.a;
        o_work.c = {i_work.b[1:0], i_work.b[31:2]};
        o_work.d = i_work.c;
        o_work.e = i_work.d;
    end

endmodule

FILE: hw/rtl/sha1_message_hasher.sv
// Top level of the SHA-1 message hasher: byte intake, padding sequencer and digest output.
// A message enters one byte per transfer and is hashed with SHA-1; a transfer with tlast set
// closes it, with or without a byte (tuser high marks a byte), so an empty message works.
// A byte that does not complete a 64-byte block leaves the intake ready. The 64th byte of a block
// starts a compression that runs one round per cycle through a single round unit: 80 rounds
// and then an add into the chaining words, during which no transfer is taken.
// Closing a message shifts in the 0x80 marker, zero fill and the eight length bytes at one
// byte per cycle while no compression runs, with a pause before the length bytes, with one
// or two compressions, and then presents the five digest words h0 to h4 as
// five output transfers, tlast on h4. A new message is accepted once the last digest word
// has been taken.
module sha1_message_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    sha1mh_pkg::t_state r_state, n_state;
    sha1mh_pkg::t_state r_ret, n_ret;
    sha1mh_pkg::t_work  r_h, n_h;
    sha1mh_pkg::t_work  r_work, n_work;
    sha1mh_pkg::t_blk   r_blk, n_blk;
    logic [5:0]         r_fill, n_fill;
    logic [63:0]        r_len, n_len;
    logic [6:0]         r_t, n_t;
    logic [2:0]         r_idx, n_idx;

    sha1mh_pkg::t_work  round_work;
    logic [31:0]        round_wt;
    logic               push;
    logic [7:0]         push_byte;

    sha1mh_round u_round (
        .i_round (r_t),
        .i_work  (r_work),
        .i_blk   (r_blk),
        .o_work  (round_work),
        .o_wt    (round_wt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1mh_pkg::ST_IDLE;
            r_ret   <= sha1mh_pkg::ST_IDLE;
            r_h     <= sha1mh_pkg::H_INIT;
            r_fill  <= '0;
            r_len   <= '0;
            r_t     <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_h     <= n_h;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_t     <= n_t;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_blk  <= n_blk;
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_h       = r_h;
        n_work    = r_work;
        n_blk     = r_blk;
        n_fill    = r_fill;
        n_len     = r_len;
        n_t       = r_t;
        n_idx     = r_idx;
        push      = 1'b0;
        push_byte = '0;

        s_axis_tready = (r_state == sha1mh_pkg::ST_IDLE);
        m_axis_tvalid = (r_state == sha1mh_pkg::ST_OUT);
        m_axis_tdata  = r_h.a;
        m_axis_tuser  = r_idx;
        m_axis_tlast  = (r_idx == sha1mh_pkg::WORD_LAST);

        case (r_state)
            sha1mh_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser) begin
                        push      = 1'b1;
                        push_byte = s_axis_tdata;
                        n_len     = r_len + 64'd8;
                    end
                    n_ret = s_axis_tlast ? sha1mh_pkg::ST_MARK : sha1mh_pkg::ST_IDLE;
                    if (s_axis_tlast) begin
                        n_state = sha1mh_pkg::ST_MARK;
                    end
                end
            end
            sha1mh_pkg::ST_MARK: begin
                push      = 1'b1;
                push_byte = sha1mh_pkg::PAD_BYTE;
                n_ret     = sha1mh_pkg::ST_ZERO;
                n_state   = sha1mh_pkg::ST_ZERO;
            end
            sha1mh_pkg::ST_ZERO: begin
                if (r_fill == sha1mh_pkg::FILL_LEN) begin
                    n_state = sha1mh_pkg::ST_LEN;
                end else begin
                    push  = 1'b1;
                    n_ret = sha1mh_pkg::ST_ZERO;
                end
            end
            sha1mh_pkg::ST_LEN: begin
                push      = 1'b1;
                push_byte = r_len[63:56];
                n_len     = {r_len[55:0], 8'h00};
                n_ret     = sha1mh_pkg::ST_OUT;
            end
            sha1mh_pkg::ST_ROUND: begin
                n_work = round_work;
                n_blk  = {r_blk[479:0], round_wt};
                if (r_t == sha1mh_pkg::ROUND_LAST) begin
                    n_t     = '0;
                    n_state = sha1mh_pkg::ST_UPDATE;
                end else begin
                    n_t = r_t + 7'd1;
                end
            end
            sha1mh_pkg::ST_UPDATE: begin
                n_h.a   = r_h.a + r_work.a;
                n_h.b   = r_h.b + r_work.b;
                n_h.c   = r_h.c + r_work.c;
                n_h.d   = r_h.d + r_work.d;
                n_h.e   = r_h.e + r_work.e;
                n_state = r_ret;
            end
            sha1mh_pkg::ST_OUT: begin
                if (m_axis_tready) begin
                    n_h.a = r_h.b;
                    n_h.b = r_h.c;
                    n_h.c = r_h.d;
                    n_h.d = r_h.e;
                    n_h.e = r_h.a;
                    if (r_idx == sha1mh_pkg::WORD_LAST) begin
                        n_h     = sha1mh_pkg::H_INIT;
                        n_idx   = '0;
                        n_len   = '0;
                        n_fill  = '0;
                        n_state = sha1mh_pkg::ST_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = sha1mh_pkg::ST_IDLE;
            end
        endcase

        // A byte entering the block window; the 64th byte of a block starts a compression.
        if (push) begin
            n_blk  = {r_blk[503:0], push_byte};
            n_fill = r_fill + 6'd1;
            if (r_fill == sha1mh_pkg::FILL_LAST) begin
                n_work  = r_h;
                n_t     = '0;
                n_state = sha1mh_pkg::ST_ROUND;
            end
        end
    end

`include "sha1_message_hasher_assert.svh"

    `SHA1MH_ASSERT_SAME(a_ready_excl, s_axis_tready, !m_axis_tvalid, "Input and output both open.")
    `SHA1MH_ASSERT_SAME(a_round_range, r_state == sha1mh_pkg::ST_ROUND, r_t <= sha1mh_pkg::ROUND_LAST, "Round count beyond the last round.")
    `SHA1MH_ASSERT_SAME(a_len_fill, r_state == sha1mh_pkg::ST_LEN, r_fill[5:3] == 3'b111, "Length bytes placed outside the block tail.")
    `SHA1MH_ASSERT_NEXT(a_restart, m_axis_tvalid && m_axis_tready && m_axis_tlast, (r_h == sha1mh_pkg::H_INIT) && (r_fill == 6'd0) && (r_len == 64'd0), "Chaining state not restored after the digest.")

endmodule
